// File: sv/crc16_frame_deframer_top_assert.svh
// ----------------------------------------------------------------------------
// crc16_frame_deframer_top_assert.svh
// Assertion macros used by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define CRC16_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define CFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Hold check: while cond is true, sig keeps its value into the next cycle.
`define CFD_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
  `CFD_ASSERT(lbl, clk, rstn, (cond) |=> $stable(sig), msg)

`endif

// File: sv/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, constants and the CRC-16 byte update for the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 2'd1;

  localparam logic [7:0] HDR_FIRST_RESET  = 8'h55;
  localparam logic [7:0] HDR_SECOND_RESET = 8'hAA;

  // Result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_CRC_OK  = 2'd1;
  localparam logic [1:0] KIND_CRC_BAD = 2'd2;

  // CRC-16 (Modbus) constants
  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Number of reserved bytes after the data
  localparam logic [15:0] RESV_LEN = 16'd4;

  // Frame phase, one-hot
  typedef enum logic [9:0] {
    PH_HUNT1  = 10'b00_0000_0001,
    PH_HUNT2  = 10'b00_0000_0010,
    PH_CMD_LO = 10'b00_0000_0100,
    PH_CMD_HI = 10'b00_0000_1000,
    PH_LEN_LO = 10'b00_0001_0000,
    PH_LEN_HI = 10'b00_0010_0000,
    PH_DATA   = 10'b00_0100_0000,
    PH_RESV   = 10'b00_1000_0000,
    PH_CRC_LO = 10'b01_0000_0000,
    PH_CRC_HI = 10'b10_0000_0000
  } phase_e;

  // Result of one byte step
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] command;
    logic [15:0] length;
  } res_t;

  // Header bytes in force
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } hdr_t;

  // Reflected CRC-16 update over one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/cfd_parser.sv
// ----------------------------------------------------------------------------
// cfd_parser
// Frame phase machine: header hunt, field capture, CRC and result decode.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     byte_i,
  input  wire cfd_pkg::hdr_t  hdr_i,
  output cfd_pkg::res_t       res_o
);

  cfd_pkg::phase_e phase_q, phase_d;
  logic [15:0] command_q, command_d;
  logic [15:0] length_q, length_d;
  logic [15:0] left_q, left_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;

  logic [15:0] crc_upd;
  logic [15:0] left_dec;
  logic [15:0] len_full;

  assign crc_upd  = cfd_pkg::crc_feed(crc_q, byte_i);
  assign left_dec = left_q - 16'd1;
  assign len_full = {byte_i, length_q[7:0]};

  // Decode the current byte against the phase
  always_comb begin
    phase_d  = phase_q;
    command_d = command_q;
    length_d = length_q;
    left_d   = left_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    res_o    = '0;
    res_o.command = command_q;
    res_o.length  = length_q;
    unique case (phase_q)
      cfd_pkg::PH_HUNT1: begin
        if (byte_i == hdr_i.first) phase_d = cfd_pkg::PH_HUNT2;
      end
      cfd_pkg::PH_HUNT2: begin
        if (byte_i == hdr_i.second) begin
          crc_d   = cfd_pkg::CRC_START;
          phase_d = cfd_pkg::PH_CMD_LO;
        end else if (byte_i != hdr_i.first) begin
          phase_d = cfd_pkg::PH_HUNT1;
        end
      end
      cfd_pkg::PH_CMD_LO: begin
        crc_d     = crc_upd;
        command_d = {8'h00, byte_i};
        phase_d   = cfd_pkg::PH_CMD_HI;
      end
      cfd_pkg::PH_CMD_HI: begin
        crc_d     = crc_upd;
        command_d = {byte_i, command_q[7:0]};
        phase_d   = cfd_pkg::PH_LEN_LO;
      end
      cfd_pkg::PH_LEN_LO: begin
        crc_d    = crc_upd;
        length_d = {8'h00, byte_i};
        phase_d  = cfd_pkg::PH_LEN_HI;
      end
      cfd_pkg::PH_LEN_HI: begin
        crc_d    = crc_upd;
        length_d = len_full;
        if (len_full != 16'd0) begin
          left_d  = len_full;
          phase_d = cfd_pkg::PH_DATA;
        end else begin
          left_d  = cfd_pkg::RESV_LEN;
          phase_d = cfd_pkg::PH_RESV;
        end
      end
      cfd_pkg::PH_DATA: begin
        crc_d      = crc_upd;
        res_o.valid = 1'b1;
        res_o.kind  = cfd_pkg::KIND_DATA;
        res_o.data  = byte_i;
        if (left_dec == 16'd0) begin
          left_d  = cfd_pkg::RESV_LEN;
          phase_d = cfd_pkg::PH_RESV;
        end else begin
          left_d = left_dec;
        end
      end
      cfd_pkg::PH_RESV: begin
        crc_d  = crc_upd;
        left_d = left_dec;
        if (left_dec == 16'd0) phase_d = cfd_pkg::PH_CRC_LO;
      end
      cfd_pkg::PH_CRC_LO: begin
        crc_lo_d = byte_i;
        phase_d  = cfd_pkg::PH_CRC_HI;
      end
      cfd_pkg::PH_CRC_HI: begin
        res_o.valid = 1'b1;
        res_o.kind  = ({byte_i, crc_lo_q} == crc_q) ? cfd_pkg::KIND_CRC_OK
                                                    : cfd_pkg::KIND_CRC_BAD;
        phase_d = cfd_pkg::PH_HUNT1;
      end
      default: begin
        phase_d = cfd_pkg::PH_HUNT1;
      end
    endcase
  end

  // Advance state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= cfd_pkg::PH_HUNT1;
      command_q <= '0;
      length_q  <= '0;
      left_q    <= '0;
      crc_q     <= cfd_pkg::CRC_START;
      crc_lo_q  <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      command_q <= command_d;
      length_q  <= length_d;
      left_q    <= left_d;
      crc_q     <= crc_d;
      crc_lo_q  <= crc_lo_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/crc16_frame_deframer_top.sv
// An accepted byte waits in the input register; one that yields a result then
// loads the result register. Throughput: one byte per cycle while the result is
// not stalled; the CRC byte update and phase step fit between these registers.
// A stalled result holds while one more byte waits in the input register.
// Reset (rst_ni low, asynchronous) empties both registers, returns to the
// header hunt and loads header bytes 0x55 and 0xAA.
// ----------------------------------------------------------------------------
// crc16_frame_deframer_top
// Byte-stream deframer with header hunt and Modbus CRC-16 check.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      out_command_o,
  output logic [15:0]      out_length_o,
  input  wire logic        cfg_we_i,
  input  wire logic [cfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  cfd_pkg::hdr_t hdr_q;
  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          out_valid_q;
  cfd_pkg::res_t out_q;
  cfd_pkg::res_t res;
  logic          out_free;
  logic          advance;
  logic          in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Write header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q.first  <= cfd_pkg::HDR_FIRST_RESET;
      hdr_q.second <= cfd_pkg::HDR_SECOND_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cfd_pkg::CFG_HEADER_FIRST:  hdr_q.first  <= cfg_data_i;
        cfd_pkg::CFG_HEADER_SECOND: hdr_q.second <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the input word until it is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_byte_q <= rx_byte_i;
  end

  cfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .hdr_i  (hdr_q),
    .res_o  (res)
  );

  // Load the result register when it is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid && out_free) out_q <= res;
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_q.kind;
  assign out_byte_o    = out_q.data;
  assign out_command_o = out_q.command;
  assign out_length_o  = out_q.length;

endmodule

`default_nettype wire

// File: sv/cfd_checker.sv
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_frame_deframer_top_assert.svh"

module cfd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  out_kind_o,
  input wire logic [7:0]  out_byte_o,
  input wire logic [15:0] out_command_o,
  input wire logic [15:0] out_length_o
);

  // A stalled result stays offered
  `CFD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")

  // A stalled result keeps its fields
  `CFD_ASSERT_HOLD(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, {out_kind_o, out_byte_o, out_command_o, out_length_o}, "result changed under stall")

  // Frame-end results carry a zero byte and a known kind
  `CFD_ASSERT(a_end_zero, clk_i, rst_ni, out_valid_o && (out_kind_o != cfd_pkg::KIND_DATA) |-> (out_byte_o == 8'h00) && (out_kind_o == cfd_pkg::KIND_CRC_OK || out_kind_o == cfd_pkg::KIND_CRC_BAD), "bad frame-end result")

  // Input never stalls while no result is pending
  `CFD_ASSERT(a_no_idle_stall, clk_i, rst_ni, !out_valid_o |-> !in_stall_o, "input stalled with empty output")

endmodule

bind crc16_frame_deframer_top cfd_checker u_cfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_kind_o    (out_kind_o),
  .out_byte_o    (out_byte_o),
  .out_command_o (out_command_o),
  .out_length_o  (out_length_o)
);

`default_nettype wire

// File: tb/sv/tb_crc16_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_crc16_frame_deframer_top
// Self-checking bench for the CRC-16 byte-stream deframer. A cycle-free
// deframer model predicts each payload word and frame verdict from the bytes
// that the block accepts. The output checker compares every word field by
// field with the oldest prediction. Directed frames cover the header hunt,
// zero and long lengths, bad CRCs and header register settings. Random
// traffic of framed and noisy bytes follows, under random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_crc16_frame_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes past the end of the list; writes to them are dropped
  localparam logic [cfd_pkg::CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [cfd_pkg::CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  localparam int unsigned GAP_PERCENT    = 12;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES   = 220;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] command;
    logic [15:0] length;
  } frame_word_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i   = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         out_kind_o;
  logic [7:0]         out_byte_o;
  logic [15:0]        out_command_o;
  logic [15:0]        out_length_o;
  logic               cfg_we_i    = 1'b0;
  logic [cfd_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [7:0]         cfg_data_i  = 8'h00;

  // Deframer model state
  logic [7:0]  hdr_first_q  = cfd_pkg::HDR_FIRST_RESET;
  logic [7:0]  hdr_second_q = cfd_pkg::HDR_SECOND_RESET;
  cfd_pkg::phase_e frame_phase = cfd_pkg::PH_HUNT1;
  logic [15:0] cmd_word     = '0;
  logic [15:0] len_word     = '0;
  logic [15:0] count_left   = '0;
  logic [15:0] crc_acc      = cfd_pkg::CRC_START;
  logic [7:0]  crc_lo_seen  = '0;

  frame_word_t pending_words[$];
  frame_word_t head_word;

  int unsigned error_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          gapless     = 1'b0;

  crc16_frame_deframer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .out_command_o (out_command_o),
    .out_length_o  (out_length_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Modbus CRC-16, one input bit at a time
  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ cfd_pkg::CRC_POLY;
    end
    return r;
  endfunction

  function automatic bit gap_roll();
    return !gapless && ($urandom_range(99, 0) < GAP_PERCENT);
  endfunction

  // Random byte that can neither start nor complete a header
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == hdr_first_q || b == hdr_second_q);
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Advance the deframer model by one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] rx_crc;
    case (frame_phase)
      cfd_pkg::PH_HUNT1: begin
        if (b == hdr_first_q) frame_phase = cfd_pkg::PH_HUNT2;
      end
      cfd_pkg::PH_HUNT2: begin
        if (b == hdr_second_q) begin
          crc_acc     = cfd_pkg::CRC_START;
          frame_phase = cfd_pkg::PH_CMD_LO;
        end else if (b != hdr_first_q) begin
          frame_phase = cfd_pkg::PH_HUNT1;
        end
      end
      cfd_pkg::PH_CMD_LO: begin
        crc_acc     = crc16_modbus_byte(crc_acc, b);
        cmd_word    = {8'h00, b};
        frame_phase = cfd_pkg::PH_CMD_HI;
      end
      cfd_pkg::PH_CMD_HI: begin
        crc_acc     = crc16_modbus_byte(crc_acc, b);
        cmd_word    = {b, cmd_word[7:0]};
        frame_phase = cfd_pkg::PH_LEN_LO;
      end
      cfd_pkg::PH_LEN_LO: begin
        crc_acc     = crc16_modbus_byte(crc_acc, b);
        len_word    = {8'h00, b};
        frame_phase = cfd_pkg::PH_LEN_HI;
      end
      cfd_pkg::PH_LEN_HI: begin
        crc_acc  = crc16_modbus_byte(crc_acc, b);
        len_word = {b, len_word[7:0]};
        if (len_word != 16'd0) begin
          count_left  = len_word;
          frame_phase = cfd_pkg::PH_DATA;
        end else begin
          count_left  = cfd_pkg::RESV_LEN;
          frame_phase = cfd_pkg::PH_RESV;
        end
      end
      cfd_pkg::PH_DATA: begin
        crc_acc = crc16_modbus_byte(crc_acc, b);
        pending_words.push_back('{cfd_pkg::KIND_DATA, b, cmd_word, len_word});
        count_left = count_left - 16'd1;
        if (count_left == 16'd0) begin
          count_left  = cfd_pkg::RESV_LEN;
          frame_phase = cfd_pkg::PH_RESV;
        end
      end
      cfd_pkg::PH_RESV: begin
        crc_acc    = crc16_modbus_byte(crc_acc, b);
        count_left = count_left - 16'd1;
        if (count_left == 16'd0) frame_phase = cfd_pkg::PH_CRC_LO;
      end
      cfd_pkg::PH_CRC_LO: begin
        crc_lo_seen = b;
        frame_phase = cfd_pkg::PH_CRC_HI;
      end
      cfd_pkg::PH_CRC_HI: begin
        rx_crc = {b, crc_lo_seen};
        pending_words.push_back('{(rx_crc == crc_acc) ? cfd_pkg::KIND_CRC_OK
                                                      : cfd_pkg::KIND_CRC_BAD,
                                  8'h00, cmd_word, len_word});
        frame_phase = cfd_pkg::PH_HUNT1;
      end
      default: begin
        frame_phase = cfd_pkg::PH_HUNT1;
      end
    endcase
  endtask

  // Offer one byte, hold it until accepted, then update the model
  task automatic send_byte(input logic [7:0] b);
    while (gap_roll()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_crc_byte(input logic [7:0] b, inout logic [15:0] crc);
    crc = crc16_modbus_byte(crc, b);
    send_byte(b);
  endtask

  task automatic send_header();
    send_byte(hdr_first_q);
    send_byte(hdr_second_q);
  endtask

  // Send command through CRC; optionally fill data with header bytes
  task automatic send_body(input logic [15:0] cmd, input logic [15:0] len,
                           input bit bad_crc, input bit hdr_data);
    logic [15:0] crc;
    logic [15:0] sent_crc;
    crc = cfd_pkg::CRC_START;
    send_crc_byte(cmd[7:0], crc);
    send_crc_byte(cmd[15:8], crc);
    send_crc_byte(len[7:0], crc);
    send_crc_byte(len[15:8], crc);
    for (int unsigned i = 0; i < len; i++) begin
      if (hdr_data) send_crc_byte(i[0] ? hdr_second_q : hdr_first_q, crc);
      else send_crc_byte(8'($urandom), crc);
    end
    repeat (cfd_pkg::RESV_LEN) send_crc_byte(8'($urandom), crc);
    sent_crc = bad_crc ? (crc ^ (16'h0001 << $urandom_range(15, 0))) : crc;
    send_byte(sent_crc[7:0]);
    send_byte(sent_crc[15:8]);
  endtask

  // Drop valid and let every pending word and in-flight byte drain
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; the caller lowers the write enable
  task automatic write_cfg(input logic [cfd_pkg::CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == cfd_pkg::CFG_HEADER_FIRST) hdr_first_q = data;
    else if (idx == cfd_pkg::CFG_HEADER_SECOND) hdr_second_q = data;
  endtask

  task automatic program_headers(input logic [7:0] first, input logic [7:0] second);
    quiesce();
    write_cfg(cfd_pkg::CFG_HEADER_FIRST, first);
    write_cfg(cfd_pkg::CFG_HEADER_SECOND, second);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_random_headers();
    int unsigned pick;
    logic [7:0]  v;
    pick = $urandom_range(99, 0);
    v    = 8'($urandom);
    if (pick < 20) program_headers(cfd_pkg::HDR_FIRST_RESET, cfd_pkg::HDR_SECOND_RESET);
    else if (pick < 35) program_headers(v, v);
    else if (pick < 43) program_headers(8'h00, 8'hFF);
    else if (pick < 50) program_headers(8'hFF, 8'h00);
    else program_headers(v, 8'($urandom));
  endtask

  // Check each accepted output word and pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with none expected", {14'd0, out_kind_o}, 16'd0);
      end else begin
        head_word = pending_words.pop_front();
        if (out_kind_o !== head_word.kind)
          report_mismatch("kind", {14'd0, out_kind_o}, {14'd0, head_word.kind});
        if (out_byte_o !== head_word.data)
          report_mismatch("byte", {8'd0, out_byte_o}, {8'd0, head_word.data});
        if (out_command_o !== head_word.command)
          report_mismatch("command", out_command_o, head_word.command);
        if (out_length_o !== head_word.length)
          report_mismatch("length", out_length_o, head_word.length);
      end
    end
    out_stall_i <= gap_roll();
  end

  // End the run when no word moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_header();
    send_body(16'h1234, 16'd3, 1'b0, 1'b0);
  endtask

  task automatic test_zero_length();
    send_header();
    send_body(16'hFFFF, 16'd0, 1'b0, 1'b0);
    send_header();
    send_body(16'h0000, 16'd0, 1'b1, 1'b0);
  endtask

  // Bad frame, then a good one to show the hunt resumes
  task automatic test_bad_crc();
    send_header();
    send_body(16'hBEEF, 16'd2, 1'b1, 1'b0);
    send_header();
    send_body(16'h00C3, 16'd1, 1'b0, 1'b0);
  endtask

  // Extra first bytes keep the hunt armed; a stray byte disarms it
  task automatic test_repeated_first();
    send_byte(hdr_first_q);
    send_byte(hdr_first_q);
    send_header();
    send_body(16'h0102, 16'd1, 1'b0, 1'b0);
    send_byte(hdr_first_q);
    send_byte(noise_byte());
    send_byte(hdr_second_q);
    send_header();
    send_body(16'h0304, 16'd0, 1'b0, 1'b0);
  endtask

  task automatic test_header_in_data();
    send_header();
    send_body({hdr_second_q, hdr_first_q}, 16'd4, 1'b0, 1'b1);
  endtask

  task automatic test_header_registers();
    program_headers(8'h00, 8'hFF);
    send_header();
    send_body(16'h8001, 16'd1, 1'b0, 1'b0);
    program_headers(8'hFF, 8'h00);
    send_byte(8'hFF);
    send_header();
    send_body(16'h7FFE, 16'd2, 1'b1, 1'b0);
    // equal registers: the second copy completes the header
    program_headers(8'h7E, 8'h7E);
    send_header();
    send_body(16'h7E7E, 16'd1, 1'b0, 1'b0);
    // writes past the register list leave the headers alone
    quiesce();
    write_cfg(CFG_SPARE_A, 8'h12);
    write_cfg(CFG_SPARE_B, 8'hED);
    cfg_we_i <= 1'b0;
    send_header();
    send_body(16'h5AA5, 16'd0, 1'b0, 1'b0);
    program_headers(cfd_pkg::HDR_FIRST_RESET, cfd_pkg::HDR_SECOND_RESET);
  endtask

  // Long data runs, the longer one without any idling
  task automatic test_long_frames();
    send_header();
    send_body(16'h0F0F, 16'd32, 1'b0, 1'b0);
    gapless = 1'b1;
    send_header();
    send_body(16'hA5A5, 16'd64, 1'b0, 1'b0);
    gapless = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned start_count;
    int unsigned next_reconfig;
    int unsigned choice;
    logic [15:0] len;
    start_count   = bytes_sent;
    next_reconfig = bytes_sent + 100;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      if (bytes_sent >= next_reconfig) begin
        program_random_headers();
        next_reconfig = bytes_sent + 100;
      end
      choice = $urandom_range(99, 0);
      if (choice < 70) begin
        len = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(40, 7))
                                          : 16'($urandom_range(6, 0));
        send_header();
        send_body(16'($urandom), len, $urandom_range(3, 0) == 0, 1'b0);
      end else if (choice < 85) begin
        repeat ($urandom_range(4, 1)) send_byte(noise_byte());
      end else begin
        // broken header; a repeat only makes sense with distinct bytes
        send_byte(hdr_first_q);
        if (hdr_first_q != hdr_second_q && $urandom_range(1, 0)) send_byte(hdr_first_q);
        send_byte(noise_byte());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_length();
    test_bad_crc();
    test_repeated_first();
    test_header_in_data();
    test_header_registers();
    test_long_frames();
    test_random_traffic();
    quiesce();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
